>>> rtl/rtba_pkg.sv
// ----------------------------------------------------------------------------
// rtba_pkg: shared types and constants for the RF time bunch averager
// Field widths, register indexes, datapath operations and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rtba_pkg;

   localparam int TIME_W      = 32;
   localparam int VAR_W       = 33;
   localparam int SUM_W       = 48;
   localparam int PERIOD_W    = 16;
   localparam int CSR_W       = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int MAX_SAMPLES = 255;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);

   // shared divider: 48-bit dividend, 17-bit divisor (twice the period, or the sample count)
   localparam int DIVIDEND_W  = 48;
   localparam int DIVISOR_W   = PERIOD_W + 1;
   localparam int DIV_STEPS   = DIVIDEND_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam int RSP_DATA_W  = ((TIME_W + VAR_W + 7) / 8) * 8;
   localparam int RSP_USER_W  = 2;

   localparam logic [PERIOD_W-1:0] BEAM_PERIOD_RESET = 16'd4008;

   localparam logic [CSR_IDX_W-1:0] REG_BEAM_PERIOD     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RESOLUTION_SQ   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_VARIANCE = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,         // capture request
      OP_OVF,          // count full: drop sample, flag overflow
      OP_ADD_RAW,      // zero period: accumulate sample as is
      OP_SHIFT_START,  // load divider with (2|d| + P) / 2P
      OP_DIV_STEP,
      OP_ACCUM,        // accumulate bunch-shifted sample
      OP_SET_INVALID,
      OP_MEAN_START,
      OP_MEAN_DONE,    // store mean, start variance division
      OP_VAR_DONE,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
      logic count_full;
      logic count_zero;
      logic period_zero;
      logic last_sample;
      logic single_zero;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/rtba_div.sv
// ----------------------------------------------------------------------------
// rtba_div: iterative restoring divider
// Unsigned divide, one quotient bit per cycle while step is held high.
// ----------------------------------------------------------------------------
module rtba_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic                                step,
   input  logic [rtba_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [rtba_pkg::DIVISOR_W-1:0]      divisor,
   output logic [rtba_pkg::DIVIDEND_W-1:0]     quotient,
   output logic [rtba_pkg::DIVISOR_W-1:0]      remainder,
   output logic                                last_step
);

   logic [rtba_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [rtba_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [rtba_pkg::DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [rtba_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [rtba_pkg::DIVISOR_W:0]    trial;
   logic                            fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[rtba_pkg::DIVIDEND_W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (load) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = '0;
      end else if (step) begin
         quo_in = {quo_ff[rtba_pkg::DIVIDEND_W-2:0], fits};
         rem_in = fits ? rtba_pkg::DIVISOR_W'(trial - {1'b0, dsr_ff})
                       : trial[rtba_pkg::DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign last_step = cnt_ff == rtba_pkg::DIV_CNT_W'(rtba_pkg::DIV_STEPS - 1);

endmodule

>>> rtl/rtba_datapath.sv
// ----------------------------------------------------------------------------
// rtba_datapath: registers, event accumulator and result register
// Executes one operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module rtba_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rtba_pkg::dp_cmd_type                 cmd,
   output rtba_pkg::dp_status_type              status,
   input  logic [rtba_pkg::TIME_W-1:0]          sample_time,
   input  logic                                 last_sample,
   input  logic                                 csr_we,
   input  logic [rtba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rtba_pkg::CSR_W-1:0]           csr_wdata,
   output logic [rtba_pkg::TIME_W-1:0]          average_time,
   output logic [rtba_pkg::VAR_W-1:0]           average_variance,
   output logic                                 variance_invalid,
   output logic                                 sample_overflow,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready
);

   localparam int TW = rtba_pkg::TIME_W;
   localparam int SW = rtba_pkg::SUM_W;
   localparam int PW = rtba_pkg::PERIOD_W;
   localparam int DW = rtba_pkg::DIVIDEND_W;
   localparam int RW = rtba_pkg::DIVISOR_W;
   localparam int CW = rtba_pkg::COUNT_W;
   localparam int VW = rtba_pkg::VAR_W;

   // configuration
   logic [PW-1:0]        period_ff;
   logic [TW-1:0]        res_sq_ff;
   logic [TW-1:0]        offset_var_ff;

   // event state
   logic [TW-1:0]        ref_ff, ref_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 ovf_ff, ovf_in;

   // working registers
   logic [TW-1:0]        t_ff, t_in;
   logic                 last_ff, last_in;
   logic [TW:0]          abs_ff, abs_in;
   logic                 sign_ff, sign_in;
   logic [TW-1:0]        mean_ff, mean_in;
   logic [VW-1:0]        var_ff, var_in;
   logic                 inv_ff, inv_in;

   // result register
   logic [TW-1:0]        rsp_time_ff, rsp_time_in;
   logic [VW-1:0]        rsp_var_ff, rsp_var_in;
   logic                 rsp_inv_ff, rsp_inv_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // divider hookup
   logic                 div_load;
   logic [DW-1:0]        div_dividend;
   logic [RW-1:0]        div_divisor;
   logic [DW-1:0]        div_quo;
   logic [RW-1:0]        div_rem;
   logic                 div_last;

   logic [VW-1:0]        single;
   logic                 count_zero;
   logic [TW+1:0]        target;
   logic [TW+1:0]        diff;
   logic [TW+1:0]        diff_abs;
   logic [TW+2:0]        twice_mag;
   logic [TW+1:0]        mag;
   logic [TW+2:0]        shifted;
   logic [SW-1:0]        sum_abs;
   logic [TW-1:0]        quo_low;

   rtba_div u_div (
      .clock     (clock),
      .reset     (reset),
      .load      (div_load),
      .step      (cmd.op == rtba_pkg::OP_DIV_STEP),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .last_step (div_last)
   );

   always_comb begin
      single     = {1'b0, res_sq_ff} + {1'b0, offset_var_ff};
      count_zero = count_ff == '0;

      // d = target - t, target is zero for the first sample of an event
      target   = count_zero ? '0 : {{2{ref_ff[TW-1]}}, ref_ff};
      diff     = target - {{2{t_ff[TW-1]}}, t_ff};
      diff_abs = diff[TW+1] ? (~diff + 1'b1) : diff;

      // n*P = (2|d| + P - r) / 2 from the divider remainder
      twice_mag = {1'b0, abs_ff, 1'b0} + {{(TW+3-PW){1'b0}}, period_ff}
                - {{(TW+3-RW){1'b0}}, div_rem};
      mag       = twice_mag[TW+2:1];
      shifted   = sign_ff ? ({{3{t_ff[TW-1]}}, t_ff} + {1'b0, mag})
                          : ({{3{t_ff[TW-1]}}, t_ff} - {1'b0, mag});

      sum_abs = sum_ff[SW-1] ? (~sum_ff + 1'b1) : sum_ff;
      quo_low = div_quo[TW-1:0];

      ref_in    = ref_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      t_in      = t_ff;
      last_in   = last_ff;
      abs_in    = abs_ff;
      sign_in   = sign_ff;
      mean_in   = mean_ff;
      var_in    = var_ff;
      inv_in    = inv_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_inv_in   = rsp_inv_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_load     = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      unique case (cmd.op)
         rtba_pkg::OP_LOAD: begin
            t_in    = sample_time;
            last_in = last_sample;
         end
         rtba_pkg::OP_OVF: begin
            ovf_in = 1'b1;
         end
         rtba_pkg::OP_ADD_RAW: begin
            if (count_zero) begin
               ref_in = t_ff;
            end
            sum_in   = sum_ff + {{(SW-TW){t_ff[TW-1]}}, t_ff};
            count_in = count_ff + 1'b1;
         end
         rtba_pkg::OP_SHIFT_START: begin
            abs_in       = diff_abs[TW:0];
            sign_in      = !diff[TW+1] && (diff != '0);
            div_load     = 1'b1;
            div_dividend = {{(DW-TW-2){1'b0}}, diff_abs[TW:0], 1'b0}
                         + {{(DW-PW){1'b0}}, period_ff};
            div_divisor  = {period_ff, 1'b0};
         end
         rtba_pkg::OP_ACCUM: begin
            // first sample: its shift toward the reference is the reference
            if (count_zero) begin
               ref_in = shifted[TW-1:0];
            end
            sum_in   = sum_ff + {{(SW-TW-3){shifted[TW+2]}}, shifted};
            count_in = count_ff + 1'b1;
         end
         rtba_pkg::OP_SET_INVALID: begin
            mean_in = ref_ff;
            var_in  = '0;
            inv_in  = 1'b1;
         end
         rtba_pkg::OP_MEAN_START: begin
            sign_in      = sum_ff[SW-1];
            div_load     = 1'b1;
            div_dividend = sum_abs;
            div_divisor  = RW'(count_ff);
         end
         rtba_pkg::OP_MEAN_DONE: begin
            mean_in      = sign_ff ? (~quo_low + 1'b1) : quo_low;
            inv_in       = 1'b0;
            div_load     = 1'b1;
            div_dividend = DW'(single);
            div_divisor  = RW'(count_ff);
         end
         rtba_pkg::OP_VAR_DONE: begin
            var_in = div_quo[VW-1:0];
         end
         rtba_pkg::OP_EMIT: begin
            rsp_time_in  = mean_ff;
            rsp_var_in   = var_ff;
            rsp_inv_in   = inv_ff;
            rsp_ovf_in   = ovf_ff;
            rsp_valid_in = 1'b1;
            ref_in       = '0;
            sum_in       = '0;
            count_in     = '0;
            ovf_in       = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= rtba_pkg::BEAM_PERIOD_RESET;
         res_sq_ff     <= '0;
         offset_var_ff <= '0;
         ref_ff        <= '0;
         sum_ff        <= '0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               rtba_pkg::REG_BEAM_PERIOD:     period_ff     <= csr_wdata[PW-1:0];
               rtba_pkg::REG_RESOLUTION_SQ:   res_sq_ff     <= csr_wdata;
               rtba_pkg::REG_OFFSET_VARIANCE: offset_var_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         ref_ff       <= ref_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff        <= t_in;
      last_ff     <= last_in;
      abs_ff      <= abs_in;
      sign_ff     <= sign_in;
      mean_ff     <= mean_in;
      var_ff      <= var_in;
      inv_ff      <= inv_in;
      rsp_time_ff <= rsp_time_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_inv_ff  <= rsp_inv_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_comb begin
      status.div_last    = div_last;
      status.count_full  = count_ff == CW'(rtba_pkg::MAX_SAMPLES);
      status.count_zero  = count_zero;
      status.period_zero = period_ff == '0;
      status.last_sample = last_ff;
      status.single_zero = single == '0;
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign average_time     = rsp_time_ff;
   assign average_variance = rsp_var_ff;
   assign variance_invalid = rsp_inv_ff;
   assign sample_overflow  = rsp_ovf_ff;
   assign rsp_valid        = rsp_valid_ff;

endmodule

>>> rtl/rtba_ctrl.sv
// ----------------------------------------------------------------------------
// rtba_ctrl: sequencing state machine
// Steps each request through shift and accumulate (or a raw add or an overflow
// drop) and, on the last sample of an event, the mean and variance divisions
// (skipped for an invalid variance) and the result write.
module rtba_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output rtba_pkg::dp_cmd_type     cmd,
   input  rtba_pkg::dp_status_type  status
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_CHECK     = 4'd1;
   localparam logic [3:0] ST_DIV_SHIFT = 4'd2;
   localparam logic [3:0] ST_ACCUM     = 4'd3;
   localparam logic [3:0] ST_END_CHECK = 4'd4;
   localparam logic [3:0] ST_DIV_MEAN  = 4'd5;
   localparam logic [3:0] ST_MEAN_DONE = 4'd6;
   localparam logic [3:0] ST_DIV_VAR   = 4'd7;
   localparam logic [3:0] ST_VAR_DONE  = 4'd8;
   localparam logic [3:0] ST_EMIT      = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = rtba_pkg::OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = rtba_pkg::OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (status.count_full) begin
               cmd.op   = rtba_pkg::OP_OVF;
               state_in = ST_END_CHECK;
            end else if (status.period_zero) begin
               cmd.op   = rtba_pkg::OP_ADD_RAW;
               state_in = ST_END_CHECK;
            end else begin
               cmd.op   = rtba_pkg::OP_SHIFT_START;
               state_in = ST_DIV_SHIFT;
            end
         end
         ST_DIV_SHIFT: begin
            cmd.op = rtba_pkg::OP_DIV_STEP;
            if (status.div_last) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.op   = rtba_pkg::OP_ACCUM;
            state_in = ST_END_CHECK;
         end
         ST_END_CHECK: begin
            priority if (!status.last_sample) begin
               state_in = ST_IDLE;
            end else if (status.single_zero || status.count_zero) begin
               cmd.op   = rtba_pkg::OP_SET_INVALID;
               state_in = ST_EMIT;
            end else begin
               cmd.op   = rtba_pkg::OP_MEAN_START;
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            cmd.op = rtba_pkg::OP_DIV_STEP;
            if (status.div_last) begin
               state_in = ST_MEAN_DONE;
            end
         end
         ST_MEAN_DONE: begin
            cmd.op   = rtba_pkg::OP_MEAN_DONE;
            state_in = ST_DIV_VAR;
         end
         ST_DIV_VAR: begin
            cmd.op = rtba_pkg::OP_DIV_STEP;
            if (status.div_last) begin
               state_in = ST_VAR_DONE;
            end
         end
         ST_VAR_DONE: begin
            cmd.op   = rtba_pkg::OP_VAR_DONE;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for the result register to drain
            if (status.out_free) begin
               cmd.op   = rtba_pkg::OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/rf_time_bunch_aligned_average.sv
// ----------------------------------------------------------------------------
// rf_time_bunch_aligned_average: bunch-aligned mean of RF time samples
// Averages the RF time samples of one event after moving each by whole beam
// periods onto the bunch of the first sample.
//
// Request channel: one sample per request, tlast marks the event's last one.
// Response channel: one result per event, sent after its last request.
// Configuration: csr_we writes csr_wdata to register csr_index (0 beam
// period, 1 resolution squared, 2 offset variance); write only while idle.
//
// Sequence: each request goes through accept, set-up, a division on the shared
// one-bit-per-cycle divider, accumulate and end check; with a zero period or a
// full sample count a raw add or an overflow drop replaces set-up, division
// and accumulate. The last request of an event then adds the mean and variance
// divisions with their store steps (skipped for an invalid variance) and the
// result write; a new request is taken only after the last one is through.
// Reset clears the event state and restores the register defaults.
// A stalled response holds in its output register; the next event's
// requests are still taken until that event needs the register itself.
// ----------------------------------------------------------------------------
module rf_time_bunch_aligned_average (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample_time [31:0]
   input  logic [rtba_pkg::TIME_W-1:0]          req_tdata,
   input  logic                                 req_tlast,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // average_time [31:0], average_variance [64:32], zero fill [71:65]
   output logic [rtba_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // variance_invalid [0], sample_overflow [1]
   output logic [rtba_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [rtba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rtba_pkg::CSR_W-1:0]           csr_wdata
);

   rtba_pkg::dp_cmd_type          cmd;
   rtba_pkg::dp_status_type       status;
   logic [rtba_pkg::TIME_W-1:0]   average_time;
   logic [rtba_pkg::VAR_W-1:0]    average_variance;
   logic                          variance_invalid;
   logic                          sample_overflow;

   rtba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .cmd       (cmd),
      .status    (status)
   );

   rtba_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .sample_time      (req_tdata),
      .last_sample      (req_tlast),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .average_time     (average_time),
      .average_variance (average_variance),
      .variance_invalid (variance_invalid),
      .sample_overflow  (sample_overflow),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready)
   );

   assign rsp_tdata = {{(rtba_pkg::RSP_DATA_W - rtba_pkg::TIME_W - rtba_pkg::VAR_W){1'b0}},
                       average_variance, average_time};
   assign rsp_tuser = {sample_overflow, variance_invalid};

endmodule

>>> rtl/rtba_checker.sv
// ----------------------------------------------------------------------------
// rtba_checker: port-level assertions for the RF time bunch averager
// Watches the request and response channels and the reset behavior.
// ----------------------------------------------------------------------------
module rtba_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [rtba_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic [rtba_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);

   // a stalled response stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // an invalid variance reports a zero variance field
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[rtba_pkg::TIME_W + rtba_pkg::VAR_W - 1:rtba_pkg::TIME_W] == '0)
      else $error("invalid variance with nonzero value");

   // each request keeps the block busy for at least the following cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken back to back");

   // reset empties the response register
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind rf_time_bunch_aligned_average rtba_checker u_rtba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
